// ===== src/grid_astar_path_search_unit_defines.svh =====
// Assertion macros shared by the search unit.
// Each one checks on the rising edge of clk and is switched off while rst_n is low.
// The synthesis versions are empty.
`ifndef GRID_ASTAR_PATH_SEARCH_UNIT_DEFINES_SVH
`define GRID_ASTAR_PATH_SEARCH_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define GAPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GAPS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define GAPS_ASSERT(lbl, prop, msg)
`define GAPS_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== src/gaps_pkg.sv =====
package gaps_pkg;

  localparam int ROW_W   = 5;
  localparam int COL_W   = 5;
  localparam int DIM_W   = 6;
  localparam int MAX_DIM = 32;
  localparam int CELL_AW = ROW_W + COL_W;
  localparam int CELLS   = MAX_DIM * MAX_DIM;
  localparam int DIST_W  = 11;
  localparam int F_W     = 12;
  localparam int LEN_W   = 10;
  localparam int KEY_W   = F_W + COL_W + ROW_W;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 6;

  localparam logic [1:0] FN_WRITE  = 2'd0;
  localparam logic [1:0] FN_SEARCH = 2'd1;
  localparam logic [1:0] FN_QUERY  = 2'd2;
  localparam logic [1:0] FN_SPARE  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_PATH  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [CFG_IW-1:0] CFG_GRID_ROWS = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_GRID_COLS = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_START_ROW = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_START_COL = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_GOAL_ROW  = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_GOAL_COL  = 3'd5;

  // Neighbour directions, in the order they are tried.
  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  typedef struct packed {
    logic [1:0]       func;
    logic [ROW_W-1:0] cell_row;
    logic [COL_W-1:0] cell_col;
    logic             wall;
  } gaps_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [LEN_W-1:0] path_len;
    logic             reached;
    logic [ROW_W-1:0] prev_row;
    logic [COL_W-1:0] prev_col;
  } gaps_out_t;

  typedef struct packed {
    logic              reached;
    logic [1:0]        dir;
    logic [DIST_W-1:0] cost;
  } cell_ent_t;

  // Field order gives the heap order (f, col, row) as a plain unsigned compare.
  typedef struct packed {
    logic [F_W-1:0]   f;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } heap_key_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_QRY, S_SINIT, S_TOP, S_POP1, S_POP2, S_POPL, S_POPA,
    S_POPB, S_POPC, S_EXP0, S_EXP1, S_NB, S_NB2, S_NXT, S_PUSHR, S_PUSHC
  } gaps_state_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] abs_diff(input logic [COL_W-1:0] a,
                                                 input logic [COL_W-1:0] b);
    return (a > b) ? DIM_W'(a - b) : DIM_W'(b - a);
  endfunction

endpackage

// ===== src/gaps_ram.sv =====
module gaps_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== src/grid_astar_path_search_unit.sv =====
// Channel  | Ports                              | Handshake
// request  | start, busy, in_data               | taken when start is high and busy low
// result   | out_valid, out_data                | one cycle strobe, cannot be held off
// config   | cfg_we, cfg_idx, cfg_data          | written on every edge with cfg_we high
//
// A wall write, or a request with an unknown function, gives its result in the cycle after
// it is taken and leaves busy low. A query's result is registered in S_QRY, after the registered read.
// A search sweeps the cell memory clear, then runs A*; each pop reads the heap's top and last
// entries, then sifts down, and a push sifts up, a level at a time on the one heap read port.
// Reset starts a sweep over every cell that opens every wall and clears the cell memory, with
// busy high. Results cannot be stalled by the receiver.
`include "grid_astar_path_search_unit_defines.svh"

module grid_astar_path_search_unit #(
  parameter int HEAP_DEPTH = 2048
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  gaps_pkg::gaps_in_t               in_data,
  output logic                             out_valid,
  output gaps_pkg::gaps_out_t              out_data,
  input  logic                             cfg_we,
  input  logic [gaps_pkg::CFG_IW-1:0]      cfg_idx,
  input  logic [gaps_pkg::CFG_DW-1:0]      cfg_data
);

  import gaps_pkg::*;

  localparam int HAW = $clog2(HEAP_DEPTH);
  localparam int CW  = $clog2(HEAP_DEPTH + 1);

  // Configuration registers.
  logic [DIM_W-1:0] rows_r, cols_r;
  logic [ROW_W-1:0] sr_r, gr_r;
  logic [COL_W-1:0] sc_r, gc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= DIM_W'(MAX_DIM);
      cols_r <= DIM_W'(MAX_DIM);
      sr_r   <= '0;
      sc_r   <= '0;
      gr_r   <= '0;
      gc_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_GRID_ROWS: rows_r <= cfg_data;
        CFG_GRID_COLS: cols_r <= cfg_data;
        CFG_START_ROW: sr_r   <= cfg_data[ROW_W-1:0];
        CFG_START_COL: sc_r   <= cfg_data[COL_W-1:0];
        CFG_GOAL_ROW:  gr_r   <= cfg_data[ROW_W-1:0];
        CFG_GOAL_COL:  gc_r   <= cfg_data[COL_W-1:0];
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0] rows_c, cols_c;
  assign rows_c = clamp_dim(rows_r);
  assign cols_c = clamp_dim(cols_r);

  // Control and datapath registers.
  gaps_state_t       state_r, state_nxt;
  logic [CELL_AW-1:0] clr_r, clr_nxt;
  logic              rst_pass_r, rst_pass_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [HAW-1:0]    hi_r, hi_nxt;
  logic [HAW-1:0]    hminidx_r, hminidx_nxt;
  heap_key_t         hmin_r, hmin_nxt;
  heap_key_t         last_r, last_nxt;
  heap_key_t         top_r, top_nxt;
  heap_key_t         pkey_r, pkey_nxt;
  logic [DIST_W-1:0] curd_r, curd_nxt;
  logic [1:0]        dir_r, dir_nxt;
  logic [ROW_W-1:0]  nbr_r, nbr_nxt, qr_r, qr_nxt, rootr_r, rootr_nxt;
  logic [COL_W-1:0]  nbc_r, nbc_nxt, qc_r, qc_nxt, rootc_r, rootc_nxt;
  logic              rootv_r, rootv_nxt;
  logic              out_valid_r, out_valid_nxt;
  gaps_out_t         out_r, out_nxt;

  // Memory ports.
  logic               wall_we, wall_wd, wall_rd;
  logic [CELL_AW-1:0] wall_wa, cell_wa, cell_ra;
  logic               cell_we;
  cell_ent_t          cell_wd, cell_rd;
  logic               heap_we;
  logic [HAW-1:0]     heap_wa, heap_ra;
  heap_key_t          heap_wd, heap_rd;

  gaps_ram #(.WIDTH(1), .DEPTH(CELLS)) u_wall_ram (
    .clk(clk), .we(wall_we), .waddr(wall_wa), .wdata(wall_wd),
    .raddr(cell_ra), .rdata(wall_rd)
  );

  gaps_ram #(.WIDTH($bits(cell_ent_t)), .DEPTH(CELLS)) u_cell_ram (
    .clk(clk), .we(cell_we), .waddr(cell_wa), .wdata(cell_wd),
    .raddr(cell_ra), .rdata(cell_rd)
  );

  gaps_ram #(.WIDTH(KEY_W), .DEPTH(HEAP_DEPTH)) u_heap_ram (
    .clk(clk), .we(heap_we), .waddr(heap_wa), .wdata(heap_wd),
    .raddr(heap_ra), .rdata(heap_rd)
  );

  // Shared combinational helpers.
  logic [HAW+1:0]    ch_idx, ch_idx1, cnt_ext;
  logic [HAW-1:0]    par_idx;
  logic [DIST_W-1:0] nd;
  logic              nb_ok, relax, at_goal, at_root;
  logic [ROW_W-1:0]  nb_row;
  logic [COL_W-1:0]  nb_col;

  assign ch_idx  = {1'b0, hi_r, 1'b1};
  assign ch_idx1 = ch_idx + 1'b1;
  assign cnt_ext = (HAW + 2)'(cnt_r);
  assign par_idx = (hi_r - 1'b1) >> 1;
  assign nd      = curd_r + 1'b1;
  assign relax   = !wall_rd && (!cell_rd.reached || (cell_rd.cost > nd));
  assign at_goal = (top_r.col == gc_r) && (top_r.row == gr_r);
  assign at_root = rootv_r && (qr_r == rootr_r) && (qc_r == rootc_r);

  // The popped cell is always inside the grid, so only the moving coordinate
  // needs a bounds check.
  always_comb begin
    nb_row = top_r.row;
    nb_col = top_r.col;
    nb_ok  = 1'b0;
    case (dir_r)
      DIR_LEFT: begin
        nb_col = top_r.col - 1'b1;
        nb_ok  = (top_r.col != '0);
      end
      DIR_DOWN: begin
        nb_row = top_r.row + 1'b1;
        nb_ok  = ({1'b0, top_r.row} + 1'b1) < rows_c;
      end
      DIR_RIGHT: begin
        nb_col = top_r.col + 1'b1;
        nb_ok  = ({1'b0, top_r.col} + 1'b1) < cols_c;
      end
      DIR_UP: begin
        nb_row = top_r.row - 1'b1;
        nb_ok  = (top_r.row != '0);
      end
      default: ;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR: begin
        if (clr_r == '1) state_nxt = rst_pass_r ? S_IDLE : S_SINIT;
      end
      S_IDLE: begin
        if (start) begin
          if (in_data.func == FN_SEARCH) state_nxt = S_CLR;
          else if (in_data.func == FN_QUERY) state_nxt = S_QRY;
        end
      end
      S_QRY: state_nxt = S_IDLE;
      S_SINIT: begin
        if ({1'b0, sr_r} >= rows_c || {1'b0, sc_r} >= cols_c ||
            {1'b0, gr_r} >= rows_c || {1'b0, gc_r} >= cols_c) state_nxt = S_IDLE;
        else state_nxt = S_PUSHR;
      end
      S_TOP:  state_nxt = (cnt_r == '0) ? S_IDLE : S_POP1;
      S_POP1: state_nxt = (cnt_r == CW'(1)) ? S_EXP0 : S_POP2;
      S_POP2: state_nxt = S_POPL;
      S_POPL: state_nxt = (ch_idx >= cnt_ext) ? S_EXP0 : S_POPA;
      S_POPA: state_nxt = (ch_idx1 < cnt_ext) ? S_POPB : S_POPC;
      S_POPB: state_nxt = S_POPC;
      S_POPC: state_nxt = (hmin_r >= last_r) ? S_EXP0 : S_POPL;
      S_EXP0: state_nxt = S_EXP1;
      S_EXP1: state_nxt = at_goal ? S_IDLE : S_NB;
      S_NB:   state_nxt = nb_ok ? S_NB2 : S_NXT;
      S_NB2: begin
        if (!relax) state_nxt = S_NXT;
        else if (cnt_r >= CW'(HEAP_DEPTH)) state_nxt = S_IDLE;
        else state_nxt = S_PUSHR;
      end
      S_NXT:   state_nxt = (dir_r == DIR_UP) ? S_TOP : S_NB;
      S_PUSHR: state_nxt = (hi_r == '0) ? S_NXT : S_PUSHC;
      S_PUSHC: state_nxt = (heap_rd <= pkey_r) ? S_NXT : S_PUSHR;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath, memory controls and results.
  always_comb begin
    clr_nxt       = clr_r;
    rst_pass_nxt  = rst_pass_r;
    cnt_nxt       = cnt_r;
    hi_nxt        = hi_r;
    hminidx_nxt   = hminidx_r;
    hmin_nxt      = hmin_r;
    last_nxt      = last_r;
    top_nxt       = top_r;
    pkey_nxt      = pkey_r;
    curd_nxt      = curd_r;
    dir_nxt       = dir_r;
    nbr_nxt       = nbr_r;
    nbc_nxt       = nbc_r;
    qr_nxt        = qr_r;
    qc_nxt        = qc_r;
    rootv_nxt     = rootv_r;
    rootr_nxt     = rootr_r;
    rootc_nxt     = rootc_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    wall_we       = 1'b0;
    wall_wa       = {in_data.cell_row, in_data.cell_col};
    wall_wd       = in_data.wall;
    cell_we       = 1'b0;
    cell_wa       = {nbr_r, nbc_r};
    cell_wd       = '0;
    cell_ra       = {nb_row, nb_col};
    heap_we       = 1'b0;
    heap_wa       = hi_r;
    heap_wd       = pkey_r;
    heap_ra       = '0;

    case (state_r)
      S_CLR: begin
        cell_we = 1'b1;
        cell_wa = clr_r;
        cell_wd = '0;
        if (rst_pass_r) begin
          wall_we = 1'b1;
          wall_wa = clr_r;
          wall_wd = 1'b0;
        end
        clr_nxt = clr_r + 1'b1;
      end
      S_IDLE: begin
        cell_ra = {in_data.cell_row, in_data.cell_col};
        if (start) begin
          qr_nxt = in_data.cell_row;
          qc_nxt = in_data.cell_col;
          if (in_data.func == FN_SEARCH) begin
            clr_nxt      = '0;
            rst_pass_nxt = 1'b0;
            cnt_nxt      = '0;
            rootv_nxt    = 1'b0;
          end else if (in_data.func != FN_QUERY) begin
            // Wall writes and unknown functions answer at once with zeros.
            wall_we       = (in_data.func == FN_WRITE);
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
          end
        end
      end
      S_QRY: begin
        out_valid_nxt = 1'b1;
        out_nxt       = '0;
        if (cell_rd.reached) begin
          out_nxt.reached  = 1'b1;
          out_nxt.prev_row = qr_r;
          out_nxt.prev_col = qc_r;
          if (!at_root) begin
            // Step back against the direction that reached this cell.
            case (cell_rd.dir)
              DIR_LEFT:  out_nxt.prev_col = qc_r + 1'b1;
              DIR_DOWN:  out_nxt.prev_row = qr_r - 1'b1;
              DIR_RIGHT: out_nxt.prev_col = qc_r - 1'b1;
              DIR_UP:    out_nxt.prev_row = qr_r + 1'b1;
              default: ;
            endcase
          end
        end
      end
      S_SINIT: begin
        if ({1'b0, sr_r} >= rows_c || {1'b0, sc_r} >= cols_c ||
            {1'b0, gr_r} >= rows_c || {1'b0, gc_r} >= cols_c) begin
          out_valid_nxt  = 1'b1;
          out_nxt        = '0;
          out_nxt.status = ST_NO_PATH;
        end else begin
          rootv_nxt = 1'b1;
          rootr_nxt = sr_r;
          rootc_nxt = sc_r;
          cell_we   = 1'b1;
          cell_wa   = {sr_r, sc_r};
          cell_wd   = '{reached: 1'b1, dir: DIR_LEFT, cost: '0};
          pkey_nxt  = '{f: '0, col: sc_r, row: sr_r};
          hi_nxt    = '0;
          cnt_nxt   = CW'(1);
          dir_nxt   = DIR_UP;
        end
      end
      S_TOP: begin
        heap_ra = '0;
        if (cnt_r == '0) begin
          out_valid_nxt  = 1'b1;
          out_nxt        = '0;
          out_nxt.status = ST_NO_PATH;
        end
      end
      S_POP1: begin
        top_nxt = heap_rd;
        cnt_nxt = cnt_r - 1'b1;
        heap_ra = HAW'(cnt_r - 1'b1);
      end
      S_POP2: begin
        last_nxt = heap_rd;
        hi_nxt   = '0;
      end
      S_POPL: begin
        heap_ra = ch_idx[HAW-1:0];
        if (ch_idx >= cnt_ext) begin
          heap_we = 1'b1;
          heap_wd = last_r;
        end
      end
      S_POPA: begin
        hmin_nxt    = heap_rd;
        hminidx_nxt = ch_idx[HAW-1:0];
        heap_ra     = ch_idx1[HAW-1:0];
      end
      S_POPB: begin
        if (heap_rd < hmin_r) begin
          hmin_nxt    = heap_rd;
          hminidx_nxt = ch_idx1[HAW-1:0];
        end
      end
      S_POPC: begin
        heap_we = 1'b1;
        if (hmin_r >= last_r) heap_wd = last_r;
        else begin
          heap_wd = hmin_r;
          hi_nxt  = hminidx_r;
        end
      end
      S_EXP0: cell_ra = {top_r.row, top_r.col};
      S_EXP1: begin
        curd_nxt = cell_rd.cost;
        dir_nxt  = DIR_LEFT;
        if (at_goal) begin
          out_valid_nxt    = 1'b1;
          out_nxt          = '0;
          out_nxt.status   = ST_OK;
          out_nxt.path_len = (cell_rd.cost > DIST_W'(1023)) ? '1
                                                            : cell_rd.cost[LEN_W-1:0];
        end
      end
      S_NB: begin
        nbr_nxt = nb_row;
        nbc_nxt = nb_col;
      end
      S_NB2: begin
        if (relax) begin
          if (cnt_r >= CW'(HEAP_DEPTH)) begin
            out_valid_nxt  = 1'b1;
            out_nxt        = '0;
            out_nxt.status = ST_OVERFLOW;
          end else begin
            cell_we  = 1'b1;
            cell_wd  = '{reached: 1'b1, dir: dir_r, cost: nd};
            pkey_nxt = '{f: F_W'(nd) + F_W'(abs_diff(nbc_r, gc_r)) +
                            F_W'(abs_diff(nbr_r, gr_r)),
                         col: nbc_r, row: nbr_r};
            hi_nxt   = cnt_r[HAW-1:0];
            cnt_nxt  = cnt_r + 1'b1;
          end
        end
      end
      S_NXT: dir_nxt = dir_r + 1'b1;
      S_PUSHR: begin
        heap_ra = par_idx;
        if (hi_r == '0) heap_we = 1'b1;
      end
      S_PUSHC: begin
        heap_we = 1'b1;
        if (heap_rd > pkey_r) begin
          heap_wd = heap_rd;
          hi_nxt  = par_idx;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      rst_pass_r  <= 1'b1;
      cnt_r       <= '0;
      rootv_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      rst_pass_r  <= rst_pass_nxt;
      cnt_r       <= cnt_nxt;
      rootv_r     <= rootv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r      <= hi_nxt;
    hminidx_r <= hminidx_nxt;
    hmin_r    <= hmin_nxt;
    last_r    <= last_nxt;
    top_r     <= top_nxt;
    pkey_r    <= pkey_nxt;
    curd_r    <= curd_nxt;
    dir_r     <= dir_nxt;
    nbr_r     <= nbr_nxt;
    nbc_r     <= nbc_nxt;
    qr_r      <= qr_nxt;
    qc_r      <= qc_nxt;
    rootr_r   <= rootr_nxt;
    rootc_r   <= rootc_nxt;
    out_r     <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `GAPS_ASSERT(a_heap_bound, cnt_r <= CW'(HEAP_DEPTH), "heap count beyond depth")
  `GAPS_ASSERT(a_sift_in_heap, (state_r == S_POPL) |-> (cnt_ext > (HAW + 2)'(hi_r)), "sift index")
  `GAPS_ASSERT(a_done_result, $fell(busy) |-> (out_valid || $past(state_r == S_CLR)), "no result")
  `GAPS_ASSERT_NEVER(a_status_code, out_valid && (out_data.status > ST_OVERFLOW), "bad status")

endmodule

// ===== tb/tb_grid_astar_path_search_unit.sv =====
`timescale 1ns / 1ps

// The testbench loads wall maps, runs searches and walks the resulting paths
// back with predecessor queries. An A* predictor inside the testbench works
// out the answer to every request, and each result strobe is checked against
// the oldest answer still waiting.
module tb_grid_astar_path_search_unit;
  import gaps_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  gaps_in_t  in_data;
  logic      out_valid;
  gaps_out_t out_data;
  logic      cfg_we;
  logic [CFG_IW-1:0] cfg_idx;
  logic [CFG_DW-1:0] cfg_data;

  grid_astar_path_search_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  localparam int HEAP_SLOTS = 2048;

  // Shadow copy of the block: registers, wall map, per-cell search results
  // and the open list of the search.
  logic [5:0]  sh_rows, sh_cols;
  logic [4:0]  sh_srow, sh_scol, sh_grow, sh_gcol;
  bit          wall_bits[CELLS];
  int          g_cost[CELLS];
  bit          seen[CELLS];
  logic [1:0]  came_from[CELLS];
  int unsigned open_list[HEAP_SLOTS];
  int          open_cnt;
  bit          root_ok;
  logic [4:0]  root_r, root_c;

  gaps_out_t answers[$];
  int        mismatches;
  int        sent;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // A run that never finishes is a failure.
  initial begin
    #800_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void open_push(int unsigned key);
    int i;
    int p;
    i = open_cnt;
    open_cnt++;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (open_list[p] <= key) break;
      open_list[i] = open_list[p];
      i = p;
    end
    open_list[i] = key;
  endfunction

  function automatic int unsigned open_pop();
    int unsigned top;
    int unsigned last;
    int i;
    int c;
    top = open_list[0];
    i = 0;
    open_cnt--;
    if (open_cnt == 0) return top;
    last = open_list[open_cnt];
    forever begin
      c = 2 * i + 1;
      if (c >= open_cnt) break;
      if (c + 1 < open_cnt && open_list[c + 1] < open_list[c]) c++;
      if (open_list[c] >= last) break;
      open_list[i] = open_list[c];
      i = c;
    end
    open_list[i] = last;
    return top;
  endfunction

  function automatic int dim_of(logic [5:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic int gap(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  // A* over the shadow wall map. Keys pack (f, col, row) so that a plain
  // unsigned compare gives the pop order.
  function automatic gaps_out_t astar_search();
    gaps_out_t res;
    int rows, cols, sr, sc, gr, gc;
    int unsigned key;
    int r, c, nr, nc, cur, ni, nd;
    res = '0;
    rows = dim_of(sh_rows);
    cols = dim_of(sh_cols);
    sr = sh_srow; sc = sh_scol; gr = sh_grow; gc = sh_gcol;
    for (int k = 0; k < CELLS; k++) seen[k] = 1'b0;
    open_cnt = 0;
    root_ok = 1'b0;
    res.status = ST_NO_PATH;
    if (sr >= rows || sc >= cols || gr >= rows || gc >= cols) return res;
    root_ok = 1'b1;
    root_r = sr;
    root_c = sc;
    g_cost[sr * MAX_DIM + sc] = 0;
    seen[sr * MAX_DIM + sc] = 1'b1;
    // The start entry goes in with an f of zero.
    open_push(sc << 5 | sr);
    while (open_cnt > 0) begin
      key = open_pop();
      c = (key >> 5) & 31;
      r = key & 31;
      cur = r * MAX_DIM + c;
      if (c == gc && r == gr) begin
        res.status = ST_OK;
        res.path_len = (g_cost[cur] > 1023) ? 10'd1023 : 10'(g_cost[cur]);
        return res;
      end
      for (int d = 0; d < 4; d++) begin
        nr = r;
        nc = c;
        case (2'(d))
          DIR_LEFT:  nc = c - 1;
          DIR_DOWN:  nr = r + 1;
          DIR_RIGHT: nc = c + 1;
          default:   nr = r - 1;
        endcase
        if (nc < 0 || nr < 0 || nc >= cols || nr >= rows) continue;
        ni = nr * MAX_DIM + nc;
        if (wall_bits[ni]) continue;
        nd = g_cost[cur] + 1;
        if (!seen[ni] || g_cost[ni] > nd) begin
          // A full open list aborts the search with the neighbour untouched.
          if (open_cnt >= HEAP_SLOTS) begin
            res.status = ST_OVERFLOW;
            return res;
          end
          g_cost[ni] = nd;
          came_from[ni] = 2'(d);
          seen[ni] = 1'b1;
          open_push((nd + gap(nc, gc) + gap(nr, gr)) << 10 | nc << 5 | nr);
        end
      end
    end
    return res;
  endfunction

  // Works out the result of one request and updates the shadow state.
  function automatic gaps_out_t predict_result(gaps_in_t rq);
    gaps_out_t res;
    int idx;
    res = '0;
    idx = rq.cell_row * MAX_DIM + rq.cell_col;
    case (rq.func)
      FN_WRITE:  wall_bits[idx] = rq.wall;
      FN_SEARCH: res = astar_search();
      FN_QUERY: begin
        if (seen[idx]) begin
          res.reached = 1'b1;
          res.prev_row = rq.cell_row;
          res.prev_col = rq.cell_col;
          // The start cell names itself as its own predecessor.
          if (!(root_ok && rq.cell_row == root_r && rq.cell_col == root_c)) begin
            case (came_from[idx])
              DIR_LEFT:  res.prev_col = rq.cell_col + 5'd1;
              DIR_DOWN:  res.prev_row = rq.cell_row - 5'd1;
              DIR_RIGHT: res.prev_col = rq.cell_col - 5'd1;
              default:   res.prev_row = rq.cell_row + 5'd1;
            endcase
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Result checker: every strobe must match the oldest waiting answer.
  always @(posedge clk) begin
    gaps_out_t want;
    if (rst_n && out_valid) begin
      if (answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        want = answers.pop_front();
        if (out_data.status !== want.status || out_data.path_len !== want.path_len ||
            out_data.reached !== want.reached || out_data.prev_row !== want.prev_row ||
            out_data.prev_col !== want.prev_col) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  // Sends one request, holding start until busy is seen low at a rising
  // edge, then idles the sender for a random number of cycles.
  task automatic send_req(logic [1:0] fn, logic [4:0] row, logic [4:0] col, logic w);
    gaps_in_t rq;
    int idle;
    rq.func = fn;
    rq.cell_row = row;
    rq.cell_col = col;
    rq.wall = w;
    start = 1'b1;
    in_data = rq;
    do @(posedge clk); while (busy);
    answers = {answers, predict_result(rq)};
    sent++;
    @(negedge clk);
    idle = ($urandom_range(0, 2) == 0) ? 0 :
           ($urandom_range(0, 15) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if (idle > 0) begin
      start = 1'b0;
      repeat (idle) @(negedge clk);
    end
  endtask

  // Holds the sender until every answer has come and the block is free.
  task automatic drain();
    start = 1'b0;
    while (answers.size() != 0 || busy) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Register writes happen only after drain, with the block idle.
  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [5:0] val);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    case (idx)
      CFG_GRID_ROWS: sh_rows = val;
      CFG_GRID_COLS: sh_cols = val;
      CFG_START_ROW: sh_srow = val[4:0];
      CFG_START_COL: sh_scol = val[4:0];
      CFG_GOAL_ROW:  sh_grow = val[4:0];
      default:       sh_gcol = val[4:0];
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_route(logic [5:0] rows, logic [5:0] cols, logic [4:0] sr,
                           logic [4:0] sc, logic [4:0] gr, logic [4:0] gc);
    drain();
    write_reg(CFG_GRID_ROWS, rows);
    write_reg(CFG_GRID_COLS, cols);
    write_reg(CFG_START_ROW, {1'b0, sr});
    write_reg(CFG_START_COL, {1'b0, sc});
    write_reg(CFG_GOAL_ROW, {1'b0, gr});
    write_reg(CFG_GOAL_COL, {1'b0, gc});
  endtask

  // Queries the goal, then follows each predecessor back towards the start.
  task automatic walk_back(int max_steps);
    logic [4:0] r, c;
    int idx;
    r = sh_grow;
    c = sh_gcol;
    for (int k = 0; k < max_steps; k++) begin
      idx = r * MAX_DIM + c;
      send_req(FN_QUERY, r, c, 1'b0);
      if (!seen[idx] || (root_ok && r == root_r && c == root_c)) break;
      case (came_from[idx])
        DIR_LEFT:  c = c + 5'd1;
        DIR_DOWN:  r = r - 5'd1;
        DIR_RIGHT: c = c - 5'd1;
        default:   r = r + 5'd1;
      endcase
    end
  endtask

  // After reset the start and goal are both (0,0): found with no steps,
  // and the start cell is its own predecessor. Cells are unreached before it.
  task automatic test_reset_values();
    send_req(FN_QUERY, 5'd3, 5'd4, 1'b0);
    send_req(FN_SEARCH, 5'd0, 5'd0, 1'b0);
    send_req(FN_QUERY, 5'd0, 5'd0, 1'b0);
    send_req(FN_QUERY, 5'd31, 5'd31, 1'b0);
  endtask

  // The unused function code changes nothing and answers with zeros.
  task automatic test_unknown_func();
    send_req(FN_SPARE, 5'd31, 5'd31, 1'b1);
    send_req(FN_SPARE, 5'd0, 5'd0, 1'b0);
  endtask

  // Corner to corner across the full open grid, then between the other two corners.
  task automatic test_full_grid();
    set_route(6'd32, 6'd32, 5'd0, 5'd0, 5'd31, 5'd31);
    send_req(FN_SEARCH, 5'd0, 5'd0, 1'b0);
    walk_back(4);
    set_route(6'd32, 6'd32, 5'd31, 5'd0, 5'd0, 5'd31);
    send_req(FN_SEARCH, 5'd0, 5'd0, 1'b0);
  endtask

  // A wall with a single gap forces a detour; the path is walked back.
  task automatic test_detour();
    set_route(6'd6, 6'd6, 5'd0, 5'd0, 5'd0, 5'd5);
    for (int r = 0; r < 5; r++) send_req(FN_WRITE, 5'(r), 5'd3, 1'b1);
    send_req(FN_SEARCH, 5'd0, 5'd0, 1'b0);
    walk_back(20);
    // Closing the gap leaves no path.
    send_req(FN_WRITE, 5'd5, 5'd3, 1'b1);
    send_req(FN_SEARCH, 5'd0, 5'd0, 1'b0);
    send_req(FN_QUERY, 5'd0, 5'd5, 1'b0);
  endtask

  // A start on a wall is still expanded; a walled goal is only found when it
  // is the start itself.
  task automatic test_walled_ends();
    set_route(6'd6, 6'd6, 5'd0, 5'd0, 5'd0, 5'd0);
    send_req(FN_WRITE, 5'd0, 5'd0, 1'b1);
    send_req(FN_SEARCH, 5'd0, 5'd0, 1'b0);
    drain();
    write_reg(CFG_GOAL_COL, 6'd1);
    send_req(FN_SEARCH, 5'd0, 5'd0, 1'b0);
    send_req(FN_WRITE, 5'd0, 5'd1, 1'b1);
    send_req(FN_SEARCH, 5'd0, 5'd0, 1'b0);
    for (int r = 0; r < 6; r++)
      for (int c = 0; c < 6; c++) send_req(FN_WRITE, 5'(r), 5'(c), 1'b0);
  endtask

  // Start or goal outside the grid gives no path and reaches nothing, and
  // out-of-range dimensions are clamped.
  task automatic test_bounds();
    set_route(6'd4, 6'd0, 5'd0, 5'd0, 5'd3, 5'd1);
    send_req(FN_SEARCH, 5'd0, 5'd0, 1'b0);
    send_req(FN_QUERY, 5'd0, 5'd0, 1'b0);
    set_route(6'd63, 6'd33, 5'd31, 5'd31, 5'd31, 5'd30);
    send_req(FN_SEARCH, 5'd0, 5'd0, 1'b0);
    walk_back(3);
  endtask

  // Random phases: new registers, some wall writes, one search and a walk
  // back along its path, with scattered queries and unused codes as noise.
  task automatic test_random_phases(int target);
    int rows, cols, n;
    logic [5:0] rv, cv;
    while (sent < target) begin
      drain();
      rows = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 10);
      cols = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 10);
      rv = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(0, 63)) : 6'(rows);
      cv = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(0, 63)) : 6'(cols);
      rows = dim_of(rv);
      cols = dim_of(cv);
      if ($urandom_range(0, 3) != 0) write_reg(CFG_GRID_ROWS, rv);
      if ($urandom_range(0, 3) != 0) write_reg(CFG_GRID_COLS, cv);
      rows = dim_of(sh_rows);
      cols = dim_of(sh_cols);
      if (rows * cols > 200 && $urandom_range(0, 2) != 0) begin
        write_reg(CFG_GRID_ROWS, 6'($urandom_range(1, 8)));
        rows = dim_of(sh_rows);
      end
      // Mostly inside the grid, now and then anywhere.
      write_reg(CFG_START_ROW, 6'($urandom_range(0, ($urandom_range(0, 15) == 0) ? 31 : rows - 1)));
      write_reg(CFG_START_COL, 6'($urandom_range(0, ($urandom_range(0, 15) == 0) ? 31 : cols - 1)));
      write_reg(CFG_GOAL_ROW, 6'($urandom_range(0, ($urandom_range(0, 15) == 0) ? 31 : rows - 1)));
      write_reg(CFG_GOAL_COL, 6'($urandom_range(0, ($urandom_range(0, 15) == 0) ? 31 : cols - 1)));
      n = $urandom_range(0, 12);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 7) == 0)
          send_req(FN_WRITE, 5'($urandom), 5'($urandom), 1'($urandom));
        else
          send_req(FN_WRITE, 5'($urandom_range(0, rows - 1)), 5'($urandom_range(0, cols - 1)),
                   ($urandom_range(0, 9) < 3));
      end
      if ($urandom_range(0, 9) == 0) send_req(FN_SPARE, 5'($urandom), 5'($urandom), 1'($urandom));
      send_req(FN_SEARCH, 5'($urandom), 5'($urandom), 1'($urandom));
      walk_back($urandom_range(1, 30));
      n = $urandom_range(0, 4);
      for (int k = 0; k < n; k++)
        send_req(FN_QUERY, 5'($urandom_range(0, rows - 1)), 5'($urandom_range(0, cols - 1)),
                 1'($urandom));
      if ($urandom_range(0, 7) == 0) send_req(FN_QUERY, 5'($urandom), 5'($urandom), 1'b0);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    mismatches = 0;
    sent = 0;
    sh_rows = 6'd32;
    sh_cols = 6'd32;
    sh_srow = '0; sh_scol = '0; sh_grow = '0; sh_gcol = '0;
    root_ok = 1'b0;
    for (int k = 0; k < CELLS; k++) begin
      wall_bits[k] = 1'b0;
      seen[k] = 1'b0;
      g_cost[k] = 0;
      came_from[k] = '0;
    end
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    test_reset_values();
    test_unknown_func();
    test_full_grid();
    test_detour();
    test_walled_ends();
    test_bounds();
    test_random_phases(850);

    drain();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && answers.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/gaps_pkg.sv
src/gaps_ram.sv
src/grid_astar_path_search_unit.sv
tb/tb_grid_astar_path_search_unit.sv
